// ----- hdl/ctsc_pkg.sv -----
// ----------------------------------------------------------------------------
// ctsc_pkg
// Shared types, codes and field layout of the cooperative thread scheduler.
// ----------------------------------------------------------------------------
package ctsc_pkg;

	localparam int DEF_MAX_THREADS    = 256;
	localparam int DEF_NUM_CONDITIONS = 4;

	localparam int FUNC_W     = 3;
	localparam int CV_SEL_W   = 2;
	localparam int CODE_W     = 3;
	localparam int TID_W      = 8;
	localparam int LIVE_W     = 9;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 32;

	localparam int OFS_RUN  = CODE_W;
	localparam int OFS_AFF  = OFS_RUN + TID_W;
	localparam int OFS_LIVE = OFS_AFF + TID_W;
	localparam int PAD_W    = OUT_DATA_W - OFS_LIVE - LIVE_W;

	typedef enum logic [1:0] {
		ST_READY    = 2'd0,
		ST_RUNNING  = 2'd1,
		ST_BLOCKED  = 2'd2,
		ST_FINISHED = 2'd3
	} tstat_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_CREATE = 3'd0,
		FN_YIELD  = 3'd1,
		FN_EXIT   = 3'd2,
		FN_WAIT   = 3'd3,
		FN_SIGNAL = 3'd4
	} func_t;

	typedef enum logic [CODE_W-1:0] {
		RC_SAME     = 3'd0,
		RC_SWITCHED = 3'd1,
		RC_FULL     = 3'd2,
		RC_HALT     = 3'd3,
		RC_DEADLOCK = 3'd4,
		RC_EMPTY    = 3'd5
	} rcode_t;

	typedef struct packed {
		logic push;
		logic pop;
	} qcmd_t;

endpackage

// ----- hdl/ctsc_ram.sv -----
// ----------------------------------------------------------------------------
// ctsc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ctsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/ctsc_qptr.sv -----
// ----------------------------------------------------------------------------
// ctsc_qptr
// Head, tail and fill count of the wait queue of each condition variable.
// ----------------------------------------------------------------------------
module ctsc_qptr #(
	parameter int MAX_THREADS    = ctsc_pkg::DEF_MAX_THREADS,
	parameter int NUM_CONDITIONS = ctsc_pkg::DEF_NUM_CONDITIONS,
	localparam int ID_W  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1,
	localparam int CNT_W = $clog2(MAX_THREADS + 1),
	localparam int CV_W  = (NUM_CONDITIONS > 1) ? $clog2(NUM_CONDITIONS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CV_W-1:0]   cv,
	input  ctsc_pkg::qcmd_t   cmd,
	output logic [ID_W-1:0]   head,
	output logic [ID_W-1:0]   tail,
	output logic [CNT_W-1:0]  fill
);

	logic [ID_W-1:0]  head_q [NUM_CONDITIONS];
	logic [ID_W-1:0]  tail_q [NUM_CONDITIONS];
	logic [CNT_W-1:0] fill_q [NUM_CONDITIONS];

	logic [CNT_W-1:0] head_inc;
	logic [CNT_W-1:0] tail_inc;
	logic [ID_W-1:0]  head_nxt;
	logic [ID_W-1:0]  tail_nxt;

	assign head = head_q[cv];
	assign tail = tail_q[cv];
	assign fill = fill_q[cv];

	assign head_inc = CNT_W'(head) + CNT_W'(1);
	assign tail_inc = CNT_W'(tail) + CNT_W'(1);
	assign head_nxt = (head_inc == CNT_W'(MAX_THREADS)) ? '0 : head_inc[ID_W-1:0];
	assign tail_nxt = (tail_inc == CNT_W'(MAX_THREADS)) ? '0 : tail_inc[ID_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CONDITIONS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			if (cmd.push) begin
				tail_q[cv] <= tail_nxt;
				fill_q[cv] <= fill + CNT_W'(1);
			end else if (cmd.pop) begin
				head_q[cv] <= head_nxt;
				fill_q[cv] <= fill - CNT_W'(1);
			end
		end
	end

endmodule

// ----- hdl/cooperative_thread_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// cooperative_thread_scheduler_core
// Round-robin thread scheduler with per-condition wait queues.
// ----------------------------------------------------------------------------
// Input stream: one scheduling event per transfer. tuser carries the event
// (create, yield, exit, wait, signal), tdata the condition variable index.
// Output stream: one result per event: result code, running thread, created
// or woken thread, and the number of allocated thread ids.
// One event is in work at a time; s_axis_tready is high only while idle.
// Yield, exit and wait run a search through the status RAM that reads one id
// per cycle over up to thread_count-1 ids. Thread status lives in a RAM with
// a registered read; wait queues live in a second RAM. The status of the
// current thread is mirrored in a register. After reset the block writes
// entry zero as running before it takes the first event. Ids above
// thread_count are never read. A result that is not taken holds the next
// event in its final step; the output register keeps the result stable until
// the transfer.
// ----------------------------------------------------------------------------
module cooperative_thread_scheduler_core #(
	parameter int MAX_THREADS    = ctsc_pkg::DEF_MAX_THREADS,
	parameter int NUM_CONDITIONS = ctsc_pkg::DEF_NUM_CONDITIONS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [ctsc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // cv_select, pad
	input  logic [ctsc_pkg::FUNC_W-1:0]        s_axis_tuser,  // func
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// result_code, running_thread, affected_thread, live_count, pad
	output logic [ctsc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	localparam int ID_W  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int CNT_W = $clog2(MAX_THREADS + 1);
	localparam int CV_W  = (NUM_CONDITIONS > 1) ? $clog2(NUM_CONDITIONS) : 1;
	localparam int QD    = NUM_CONDITIONS * MAX_THREADS;
	localparam int FA_W  = (QD > 1) ? $clog2(QD) : 1;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DISPATCH,
		S_SEARCH,
		S_SW_OLD,
		S_SW_NEW,
		S_SIG_STAT,
		S_SIG_WR,
		S_DONE
	} state_t;

	state_t                     state_q;
	ctsc_pkg::func_t            func_q;
	logic [CV_W-1:0]            cv_q;
	logic [ID_W-1:0]            cur_q;
	ctsc_pkg::tstat_t           cur_st_q;
	logic [CNT_W-1:0]           count_q;
	logic [ID_W-1:0]            target_q;
	ctsc_pkg::rcode_t           code_q;
	ctsc_pkg::rcode_t           none_code_q;
	logic [ID_W-1:0]            affected_q;
	logic [ID_W-1:0]            scan_q;
	logic [CNT_W-1:0]           remain_q;
	logic                       issued_s1;
	logic [ID_W-1:0]            addr_s1;
	logic                       out_valid_q;
	logic [ctsc_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                       out_load;

	// condition index modulo NUM_CONDITIONS
	logic [2:0]                 cv_red;
	logic [CV_W+2:0]            cv_ext;
	logic [CV_W-1:0]            cv_mod;

	logic [CNT_W-1:0]           scan_inc;
	logic [ID_W-1:0]            scan_nxt;
	logic [CNT_W-1:0]           cur_inc;
	logic [ID_W-1:0]            cur_nxt;

	logic                       st_we;
	logic [ID_W-1:0]            st_waddr;
	ctsc_pkg::tstat_t           st_wdata;
	logic [ID_W-1:0]            st_raddr;
	logic [1:0]                 st_rdata;
	logic                       found;

	ctsc_pkg::qcmd_t            qcmd;
	logic [ID_W-1:0]            q_head;
	logic [ID_W-1:0]            q_tail;
	logic [CNT_W-1:0]           q_fill;
	logic                       q_full;
	logic [FA_W-1:0]            q_base;
	logic [FA_W-1:0]            q_waddr;
	logic [FA_W-1:0]            q_raddr;
	logic [ID_W-1:0]            q_rdata;

	logic [ID_W+ctsc_pkg::TID_W-1:0]    run_w;
	logic [ID_W+ctsc_pkg::TID_W-1:0]    aff_w;
	logic [CNT_W+ctsc_pkg::LIVE_W-1:0]  live_w;

	always_comb begin
		cv_red = {1'b0, s_axis_tdata[ctsc_pkg::CV_SEL_W-1:0]};
		for (int i = 0; i < 3; i++) begin
			if (int'(cv_red) >= NUM_CONDITIONS) begin
				cv_red = cv_red - 3'(NUM_CONDITIONS);
			end
		end
		cv_ext = {CV_W'(0), cv_red};
		cv_mod = cv_ext[CV_W-1:0];
	end

	assign scan_inc = CNT_W'(scan_q) + CNT_W'(1);
	assign scan_nxt = (scan_inc == count_q) ? '0 : scan_inc[ID_W-1:0];
	assign cur_inc  = CNT_W'(cur_q) + CNT_W'(1);
	assign cur_nxt  = (cur_inc == count_q) ? '0 : cur_inc[ID_W-1:0];

	assign found = issued_s1 && (ctsc_pkg::tstat_t'(st_rdata) == ctsc_pkg::ST_READY);

	// status RAM write port
	always_comb begin
		st_we    = 1'b0;
		st_waddr = cur_q;
		st_wdata = ctsc_pkg::ST_READY;
		unique case (state_q)
			S_INIT: begin
				st_we    = 1'b1;
				st_waddr = '0;
				st_wdata = ctsc_pkg::ST_RUNNING;
			end
			S_DISPATCH: begin
				if (func_q == ctsc_pkg::FN_EXIT) begin
					st_we    = 1'b1;
					st_wdata = ctsc_pkg::ST_FINISHED;
				end else if (func_q == ctsc_pkg::FN_WAIT) begin
					st_we    = (cur_st_q != ctsc_pkg::ST_FINISHED);
					st_wdata = ctsc_pkg::ST_BLOCKED;
				end
			end
			S_SW_OLD: begin
				st_we    = (cur_st_q == ctsc_pkg::ST_RUNNING);
				st_wdata = ctsc_pkg::ST_READY;
			end
			S_SW_NEW: begin
				st_we    = 1'b1;
				st_waddr = target_q;
				st_wdata = ctsc_pkg::ST_RUNNING;
			end
			S_SIG_WR: begin
				st_we    = (ctsc_pkg::tstat_t'(st_rdata) != ctsc_pkg::ST_FINISHED);
				st_waddr = target_q;
				st_wdata = (target_q == cur_q) ? ctsc_pkg::ST_RUNNING : ctsc_pkg::ST_READY;
			end
			default: begin
			end
		endcase
	end

	assign st_raddr = (state_q == S_SIG_STAT) ? q_rdata : scan_q;

	ctsc_ram #(
		.WIDTH (2),
		.DEPTH (MAX_THREADS)
	) u_status_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// wait queues
	assign q_full    = (q_fill == CNT_W'(MAX_THREADS));
	assign qcmd.push = (state_q == S_DISPATCH) && (func_q == ctsc_pkg::FN_WAIT) && !q_full;
	assign qcmd.pop  = (state_q == S_DISPATCH) && (func_q == ctsc_pkg::FN_SIGNAL) &&
		(q_fill != '0);
	assign q_base    = FA_W'(cv_q) * FA_W'(MAX_THREADS);
	assign q_waddr   = q_base + FA_W'(q_tail);
	assign q_raddr   = q_base + FA_W'(q_head);

	ctsc_qptr #(
		.MAX_THREADS    (MAX_THREADS),
		.NUM_CONDITIONS (NUM_CONDITIONS)
	) u_qptr (
		.clk    (clk),
		.arst_n (arst_n),
		.cv     (cv_q),
		.cmd    (qcmd),
		.head   (q_head),
		.tail   (q_tail),
		.fill   (q_fill)
	);

	ctsc_ram #(
		.WIDTH (ID_W),
		.DEPTH (QD)
	) u_queue_ram (
		.clk   (clk),
		.we    (qcmd.push),
		.waddr (q_waddr),
		.wdata (cur_q),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	assign run_w  = {ctsc_pkg::TID_W'(0), cur_q};
	assign aff_w  = {ctsc_pkg::TID_W'(0), affected_q};
	assign live_w = {ctsc_pkg::LIVE_W'(0), count_q};

	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			func_q      <= ctsc_pkg::FN_YIELD;
			cv_q        <= '0;
			cur_q       <= '0;
			cur_st_q    <= ctsc_pkg::ST_RUNNING;
			count_q     <= CNT_W'(1);
			target_q    <= '0;
			code_q      <= ctsc_pkg::RC_SAME;
			none_code_q <= ctsc_pkg::RC_SAME;
			affected_q  <= '0;
			scan_q      <= '0;
			remain_q    <= '0;
			issued_s1   <= 1'b0;
			addr_s1     <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						func_q     <= ctsc_pkg::func_t'(s_axis_tuser);
						cv_q       <= cv_mod;
						code_q     <= ctsc_pkg::RC_SAME;
						affected_q <= '0;
						state_q    <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					scan_q    <= cur_nxt;
					remain_q  <= count_q - CNT_W'(1);
					issued_s1 <= 1'b0;
					unique case (func_q)
						ctsc_pkg::FN_CREATE: begin
							if (count_q == CNT_W'(MAX_THREADS)) begin
								code_q  <= ctsc_pkg::RC_FULL;
								state_q <= S_DONE;
							end else begin
								target_q   <= count_q[ID_W-1:0];
								affected_q <= count_q[ID_W-1:0];
								count_q    <= count_q + CNT_W'(1);
								code_q     <= ctsc_pkg::RC_SWITCHED;
								state_q    <= S_SW_OLD;
							end
						end
						ctsc_pkg::FN_YIELD: begin
							none_code_q <= ctsc_pkg::RC_SAME;
							state_q     <= S_SEARCH;
						end
						ctsc_pkg::FN_EXIT: begin
							cur_st_q    <= ctsc_pkg::ST_FINISHED;
							none_code_q <= ctsc_pkg::RC_HALT;
							state_q     <= S_SEARCH;
						end
						ctsc_pkg::FN_WAIT: begin
							if (cur_st_q != ctsc_pkg::ST_FINISHED) begin
								cur_st_q <= ctsc_pkg::ST_BLOCKED;
							end
							none_code_q <= ctsc_pkg::RC_DEADLOCK;
							state_q     <= S_SEARCH;
						end
						ctsc_pkg::FN_SIGNAL: begin
							if (q_fill == '0) begin
								code_q  <= ctsc_pkg::RC_EMPTY;
								state_q <= S_DONE;
							end else begin
								state_q <= S_SIG_STAT;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_SEARCH: begin
					if (found) begin
						target_q <= addr_s1;
						code_q   <= ctsc_pkg::RC_SWITCHED;
						state_q  <= S_SW_OLD;
					end else if (remain_q == '0) begin
						code_q  <= none_code_q;
						state_q <= S_DONE;
					end else begin
						issued_s1 <= 1'b1;
						addr_s1   <= scan_q;
						scan_q    <= scan_nxt;
						remain_q  <= remain_q - CNT_W'(1);
					end
				end
				S_SW_OLD: begin
					state_q <= S_SW_NEW;
				end
				S_SW_NEW: begin
					cur_q    <= target_q;
					cur_st_q <= ctsc_pkg::ST_RUNNING;
					state_q  <= S_DONE;
				end
				S_SIG_STAT: begin
					target_q <= q_rdata;
					state_q  <= S_SIG_WR;
				end
				S_SIG_WR: begin
					affected_q <= target_q;
					if ((ctsc_pkg::tstat_t'(st_rdata) != ctsc_pkg::ST_FINISHED) &&
						(target_q == cur_q)) begin
						cur_st_q <= ctsc_pkg::ST_RUNNING;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_data_q  <= {ctsc_pkg::PAD_W'(0),
							live_w[ctsc_pkg::LIVE_W-1:0],
							aff_w[ctsc_pkg::TID_W-1:0],
							run_w[ctsc_pkg::TID_W-1:0],
							code_q};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ----- hdl/ctsc_checker.sv -----
// ----------------------------------------------------------------------------
// ctsc_checker
// Port-level checks of the scheduler core, bound to the top level.
// ----------------------------------------------------------------------------
module ctsc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [ctsc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	logic [ctsc_pkg::CODE_W-1:0] code;
	logic [ctsc_pkg::TID_W-1:0]  aff;

	assign code = m_axis_tdata[ctsc_pkg::CODE_W-1:0];
	assign aff  = m_axis_tdata[ctsc_pkg::OFS_AFF +: ctsc_pkg::TID_W];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one event in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("transfer taken while busy");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> code <= 3'(ctsc_pkg::RC_EMPTY))
		else $error("result code out of range");

	// full table and empty queue report no thread
	a_noaff: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (code == 3'(ctsc_pkg::RC_FULL) || code == 3'(ctsc_pkg::RC_EMPTY))
		|-> aff == '0)
		else $error("affected thread set on full or empty");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[ctsc_pkg::OUT_DATA_W-1 -: ctsc_pkg::PAD_W] == '0)
		else $error("pad bits not zero");

endmodule

bind cooperative_thread_scheduler_core ctsc_checker u_ctsc_checker (.*);

// ----- test/cooperative_thread_scheduler_core_tb.sv -----
// ----------------------------------------------------------------------------
// cooperative_thread_scheduler_core_tb
// Self-checking regression of the thread scheduler core. A driver sends
// scheduling events (create, yield, exit, wait, signal and the unused codes)
// from a queue. A predictor keeps its own status table and per-condition wait
// queues and works out each result at the input transfer. A monitor compares
// every output transfer with the oldest prediction. Stimulus: a directed run
// through the corner cases, a wait-queue overflow, random traffic, a fill of
// the id table and random traffic on a full table. Both sides idle at random,
// and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module cooperative_thread_scheduler_core_tb;
	import ctsc_pkg::*;

	localparam int MAX_THREADS = DEF_MAX_THREADS;
	localparam int NUM_COND    = DEF_NUM_CONDITIONS;
	localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;
	localparam int RX_HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES   = 300;

	typedef struct {
		logic [FUNC_W-1:0]   func;
		logic [CV_SEL_W-1:0] cv;
	} sched_event_t;

	typedef struct {
		rcode_t            code;
		logic [TID_W-1:0]  running;
		logic [TID_W-1:0]  affected;
		logic [LIVE_W-1:0] live;
	} sched_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [FUNC_W-1:0]     s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// predictor state
	tstat_t sched_status [MAX_THREADS];
	int     sched_count;
	int     sched_cur;
	int     cond_q [NUM_COND][$];

	sched_event_t  event_q [$];
	sched_result_t pending_results [$];

	int events_sent;
	int results_seen;
	int mismatches;
	int code_hits [8];
	int tx_gap;
	bit tx_steady;
	int rx_stall;
	int rx_hold;
	bit rx_hold_done;
	bit rx_steady;

	cooperative_thread_scheduler_core #(
		.MAX_THREADS(MAX_THREADS),
		.NUM_CONDITIONS(NUM_COND)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	function automatic bit find_ready(output int id);
		id = 0;
		for (int i = 1; i < sched_count; i++) begin
			if (sched_status[(sched_cur + i) % sched_count] == ST_READY) begin
				id = (sched_cur + i) % sched_count;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void switch_to(int id);
		if (sched_status[sched_cur] == ST_RUNNING)
			sched_status[sched_cur] = ST_READY;
		sched_status[id] = ST_RUNNING;
		sched_cur = id;
	endfunction

	function automatic rcode_t yield_or(rcode_t none_code);
		int id;
		if (!find_ready(id))
			return none_code;
		switch_to(id);
		return RC_SWITCHED;
	endfunction

	function automatic sched_result_t predict_event(logic [FUNC_W-1:0] fn,
			logic [CV_SEL_W-1:0] cv);
		sched_result_t r;
		int id;
		int sel;
		sel = int'(cv) % NUM_COND;
		r.code = RC_SAME;
		r.affected = '0;
		id = 0;
		case (fn)
			FN_CREATE: begin
				if (sched_count >= MAX_THREADS) begin
					r.code = RC_FULL;
				end else begin
					id = sched_count;
					sched_count++;
					switch_to(id);
					r.affected = id[TID_W-1:0];
					r.code = RC_SWITCHED;
				end
			end
			FN_YIELD: r.code = yield_or(RC_SAME);
			FN_EXIT: begin
				sched_status[sched_cur] = ST_FINISHED;
				r.code = yield_or(RC_HALT);
			end
			FN_WAIT: begin
				if (sched_status[sched_cur] != ST_FINISHED)
					sched_status[sched_cur] = ST_BLOCKED;
				if (cond_q[sel].size() < MAX_THREADS)
					cond_q[sel].push_back(sched_cur);
				r.code = yield_or(RC_DEADLOCK);
			end
			FN_SIGNAL: begin
				if (cond_q[sel].size() == 0) begin
					r.code = RC_EMPTY;
				end else begin
					id = cond_q[sel].pop_front();
					if (sched_status[id] != ST_FINISHED)
						sched_status[id] = (id == sched_cur) ? ST_RUNNING : ST_READY;
					r.affected = id[TID_W-1:0];
				end
			end
			default: ;
		endcase
		r.running = sched_cur[TID_W-1:0];
		r.live = sched_count[LIVE_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic sched_event_t rand_event();
		sched_event_t ev;
		int r;
		r = $urandom_range(0, 99);
		ev.cv = CV_SEL_W'($urandom_range(0, NUM_COND - 1));
		if (r < 12)
			ev.func = FN_CREATE;
		else if (r < 30)
			ev.func = FN_YIELD;
		else if (r < 44)
			ev.func = FN_EXIT;
		else if (r < 66)
			ev.func = FN_WAIT;
		else if (r < 95)
			ev.func = FN_SIGNAL;
		else
			ev.func = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
		return ev;
	endfunction

	task automatic queue_event(logic [FUNC_W-1:0] fn, logic [CV_SEL_W-1:0] cv);
		sched_event_t ev;
		ev.func = fn;
		ev.cv = cv;
		event_q.push_back(ev);
	endtask

	task automatic wait_idle();
		while (event_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// driver: predicts at each input transfer
	always @(posedge clk or negedge arst_n) begin : drive_proc
		sched_event_t  ev;
		sched_result_t want;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			tx_gap <= 0;
			tx_steady <= 1'b0;
		end else begin
			if ($urandom_range(0, 99) == 0)
				tx_steady <= !tx_steady;
			if (s_axis_tvalid && s_axis_tready) begin
				want = predict_event(s_axis_tuser, s_axis_tdata[CV_SEL_W-1:0]);
				pending_results.push_back(want);
				code_hits[want.code]++;
				events_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0 || event_q.size() == 0) begin
					s_axis_tvalid <= 1'b0;
					if (tx_gap > 0)
						tx_gap <= tx_gap - 1;
				end else begin
					ev = event_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= ev.func;
					s_axis_tdata <= {{(IN_DATA_W - CV_SEL_W){1'b0}}, ev.cv};
					tx_gap <= tx_steady ? 0 : pick_gap();
				end
			end
		end
	end

	// receiver backpressure, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_stall <= 0;
			rx_hold <= 0;
			rx_hold_done <= 1'b0;
			rx_steady <= 1'b0;
		end else begin
			if ($urandom_range(0, 99) == 0)
				rx_steady <= !rx_steady;
			if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				m_axis_tready <= 1'b0;
			end else if (!rx_hold_done && results_seen >= 60) begin
				rx_hold <= RX_HOLD_CYCLES;
				rx_hold_done <= 1'b1;
				m_axis_tready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall <= rx_stall - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				rx_stall <= rx_steady ? 0 : pick_gap();
			end
		end
	end

	// monitor
	always @(posedge clk) begin : check_proc
		sched_result_t want;
		logic [CODE_W-1:0] got_code;
		logic [TID_W-1:0]  got_run;
		logic [TID_W-1:0]  got_aff;
		logic [LIVE_W-1:0] got_live;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			got_code = m_axis_tdata[CODE_W-1:0];
			got_run = m_axis_tdata[OFS_RUN +: TID_W];
			got_aff = m_axis_tdata[OFS_AFF +: TID_W];
			got_live = m_axis_tdata[OFS_LIVE +: LIVE_W];
			if (pending_results.size() == 0) begin
				note_failure($sformatf("result %0d with none outstanding: tdata %h",
					results_seen, m_axis_tdata));
			end else begin
				want = pending_results.pop_front();
				if (got_code != want.code || got_run != want.running
						|| got_aff != want.affected || got_live != want.live)
					note_failure($sformatf(
						"result %0d: expected code %0d run %0d aff %0d live %0d, got %0d %0d %0d %0d",
						results_seen, want.code, want.running, want.affected, want.live,
						got_code, got_run, got_aff, got_live));
			end
		end
	end

	initial begin
		#15_000_000;
		$display("cooperative_thread_scheduler_core regression: fail");
		$finish;
	end

	initial begin
		int n;
		for (int i = 0; i < MAX_THREADS; i++)
			sched_status[i] = ST_READY;
		sched_status[0] = ST_RUNNING;
		sched_count = 1;
		sched_cur = 0;

		// corner cases on a small table
		queue_event(FN_UNUSED_LO, 0);
		queue_event(FN_YIELD, 0);
		queue_event(FN_SIGNAL, 0);
		queue_event(FN_CREATE, 3);
		queue_event(FN_CREATE, 0);
		queue_event(FN_YIELD, 1);
		queue_event(FN_WAIT, 1);
		queue_event(FN_SIGNAL, 1);
		queue_event(FN_EXIT, 0);
		queue_event(FN_WAIT, 2);
		queue_event(FN_WAIT, 1);
		queue_event(FN_YIELD, 0);
		queue_event(FN_CREATE, 0);
		queue_event(FN_SIGNAL, 1);
		queue_event(FN_WAIT, 3);
		queue_event(FN_SIGNAL, 2);
		queue_event(FN_UNUSED_HI, 3);
		queue_event(FN_EXIT, 0);
		queue_event(FN_EXIT, 0);
		queue_event(FN_WAIT, 0);
		queue_event(FN_SIGNAL, 0);
		queue_event(FN_SIGNAL, 3);
		queue_event(FN_YIELD, 0);
		queue_event(FN_WAIT, 1);
		queue_event(FN_SIGNAL, 1);

		// overflow one wait queue, then wake a few
		for (int i = 0; i < MAX_THREADS + 2; i++)
			queue_event(FN_WAIT, 2);
		for (int i = 0; i < 3; i++)
			queue_event(FN_SIGNAL, 2);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 60; i++)
			event_q.push_back(rand_event());

		// sender pauses here until everything is back
		wait_idle();
		n = MAX_THREADS - sched_count + 2;
		for (int i = 0; i < n; i++)
			queue_event(FN_CREATE, CV_SEL_W'($urandom_range(0, NUM_COND - 1)));
		for (int i = 0; i < 100; i++)
			event_q.push_back(rand_event());

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d events, %0d results; codes same/switch/full/halt/deadlock/empty: %0d/%0d/%0d/%0d/%0d/%0d",
			events_sent, results_seen, code_hits[RC_SAME], code_hits[RC_SWITCHED],
			code_hits[RC_FULL], code_hits[RC_HALT], code_hits[RC_DEADLOCK], code_hits[RC_EMPTY]);
		$display("table reached %0d ids; %0d mismatches", sched_count, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("cooperative_thread_scheduler_core regression: pass");
		end else begin
			$display("cooperative_thread_scheduler_core regression: fail");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/ctsc_pkg.sv
hdl/ctsc_ram.sv
hdl/ctsc_qptr.sv
hdl/cooperative_thread_scheduler_core.sv
hdl/ctsc_checker.sv
test/cooperative_thread_scheduler_core_tb.sv
